@@ design/assert_macros.svh @@
// assertion macros used by the rtl of the toolpath move emitter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ design/tme_pkg.sv @@
// shared constants, codes and helpers of the toolpath move emitter
package tme_pkg;

    // default widths
    localparam int COORD_BITS_DEF   = 20;
    localparam int EXTRUDE_BITS_DEF = 40;

    // fixed field widths
    localparam int KIND_BITS     = 2;
    localparam int SPEED_BITS    = 8;
    localparam int FEED_BITS     = 14;
    localparam int GAIN_BITS     = 16;
    localparam int RETRACT_BITS  = 16;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;

    // configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TRAVEL_SPEED   = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RETRACT_LENGTH = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_EXTRUDE_GAIN   = 2'd2;

    // configuration reset values
    localparam logic [SPEED_BITS-1:0]   TRAVEL_SPEED_RST   = 8'd75;
    localparam logic [RETRACT_BITS-1:0] RETRACT_LENGTH_RST = 16'd6000;
    localparam logic [GAIN_BITS-1:0]    EXTRUDE_GAIN_RST   = 16'd2180;

    // input move kinds
    localparam logic [KIND_BITS-1:0] KIND_TRAVEL  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_PRINT   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_RETRACT = 2'd2;

    // output line kinds
    localparam logic [KIND_BITS-1:0] LINE_TRAVEL  = 2'd0;
    localparam logic [KIND_BITS-1:0] LINE_PRINT   = 2'd1;
    localparam logic [KIND_BITS-1:0] LINE_EXTRUDE = 2'd2;

    // mm per second to mm per minute: s*64 - s*4
    function automatic logic [FEED_BITS-1:0] feed_of(input logic [SPEED_BITS-1:0] speed);
        return {speed, 6'b0} - {4'b0, speed, 2'b0};
    endfunction

endpackage

@@ design/toolpath_move_emitter_unit.sv @@
// toolpath move emitter: move filtering, path length and extruder bookkeeping
`include "assert_macros.svh"

// Turns target positions into motion lines. Each input beat carries a move kind
// (travel, print, travel with retraction) on s_tuser and X/Y/Z plus a print speed
// on s_tdata. A move equal in X, Y, Z and feed to the last one is dropped. A print
// move adds isqrt(dx^2+dy^2) * extrude_gain >> 16 to the extruder total. A
// retracting travel gives a retract line, the travel line unless dropped, and an
// unretract line; the last beat of an item has m_tlast set. One item is worked on
// at a time. A travel passes the drop test and then gives its move line; a print
// move also runs through the bit-serial squaring, the one-bit-per-cycle square
// root and the bit-serial gain multiply before its line; a retraction adds one
// state per extruder-only line. Results sit in an output register, so the next
// item is taken while the last beat still waits for m_tready.
module toolpath_move_emitter_unit #(
    parameter int COORD_BITS   = tme_pkg::COORD_BITS_DEF,
    parameter int EXTRUDE_BITS = tme_pkg::EXTRUDE_BITS_DEF,
    localparam int S_RAW    = 3 * COORD_BITS + tme_pkg::SPEED_BITS,
    localparam int S_DATA_W = ((S_RAW + 7) / 8) * 8,
    localparam int M_RAW    = 3 * COORD_BITS + 2 + tme_pkg::FEED_BITS + EXTRUDE_BITS,
    localparam int M_DATA_W = ((M_RAW + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [tme_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [tme_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // input beats
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_DATA_W-1:0]                s_tdata,  // target_x, target_y, target_z, print_speed
    input  logic [tme_pkg::KIND_BITS-1:0]      s_tuser,  // kind
    // result beats
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [M_DATA_W-1:0]                m_tdata,  // out_x, out_y, out_z, z_changed, feed,
                                                         // feed_changed, extruder_total
    output logic [tme_pkg::KIND_BITS-1:0]      m_tuser,  // line_kind
    output logic                               m_tlast   // last
);

    localparam int SQ_BITS   = 2 * COORD_BITS;        // one square
    localparam int SUM_BITS  = SQ_BITS + 1;           // sum of two squares
    localparam int RAD_BITS  = SQ_BITS + 2;           // radicand padded to whole pairs
    localparam int ROOT_BITS = COORD_BITS + 1;        // path length
    localparam int REM_BITS  = ROOT_BITS + 2;
    localparam int PROD_W    = ROOT_BITS + tme_pkg::GAIN_BITS;
    localparam int WIDE_W    = EXTRUDE_BITS + ROOT_BITS;
    localparam int CNT_MAX   = (COORD_BITS > tme_pkg::GAIN_BITS) ? COORD_BITS
                                                                 : tme_pkg::GAIN_BITS;
    localparam int CNT_W     = $clog2(CNT_MAX + 1);
    localparam int FW        = tme_pkg::FEED_BITS;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;  // waiting for an input beat
    localparam logic [2:0] ST_CHECK  = 3'd1;  // drop test and setup
    localparam logic [2:0] ST_SQ     = 3'd2;  // bit-serial dx^2 + dy^2
    localparam logic [2:0] ST_ROOT   = 3'd3;  // one root bit per cycle
    localparam logic [2:0] ST_MUL    = 3'd4;  // bit-serial length * gain
    localparam logic [2:0] ST_MOVE   = 3'd5;  // emit travel or print line
    localparam logic [2:0] ST_RETR   = 3'd6;  // emit retract line
    localparam logic [2:0] ST_UNRETR = 3'd7;  // emit unretract line

    // input field unpacking
    logic [COORD_BITS-1:0]          s_x, s_y, s_z;
    logic [tme_pkg::SPEED_BITS-1:0] s_speed;

    assign s_x     = s_tdata[COORD_BITS-1:0];
    assign s_y     = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign s_z     = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign s_speed = s_tdata[3*COORD_BITS+tme_pkg::SPEED_BITS-1:3*COORD_BITS];

    // control and state registers
    logic [2:0]                        state_reg, state_next;
    logic [tme_pkg::SPEED_BITS-1:0]    travel_speed_reg, travel_speed_next;
    logic [tme_pkg::RETRACT_BITS-1:0]  retract_length_reg, retract_length_next;
    logic [tme_pkg::GAIN_BITS-1:0]     extrude_gain_reg, extrude_gain_next;
    logic [COORD_BITS-1:0]             prev_x_reg, prev_x_next;
    logic [COORD_BITS-1:0]             prev_y_reg, prev_y_next;
    logic [COORD_BITS-1:0]             prev_z_reg, prev_z_next;
    logic [FW-1:0]                     prev_feed_reg, prev_feed_next;
    logic [EXTRUDE_BITS-1:0]           acc_reg, acc_next;
    logic                              m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;

    // item payload
    logic                              print_reg, print_next;
    logic                              retr_reg, retr_next;
    logic [COORD_BITS-1:0]             tx_reg, tx_next, ty_reg, ty_next, tz_reg, tz_next;
    logic [FW-1:0]                     feed_reg, feed_next;

    // arithmetic shift registers
    logic [SQ_BITS-1:0]                mcx_reg, mcx_next, mcy_reg, mcy_next;
    logic [COORD_BITS-1:0]             mpx_reg, mpx_next, mpy_reg, mpy_next;
    logic [SUM_BITS-1:0]               sum_reg, sum_next;
    logic [RAD_BITS-1:0]               rad_reg, rad_next;
    logic [ROOT_BITS-1:0]              root_reg, root_next;
    logic [REM_BITS-1:0]               rem_reg, rem_next;
    logic [PROD_W-1:0]                 mmc_reg, mmc_next, prod_reg, prod_next;
    logic [tme_pkg::GAIN_BITS-1:0]     gsh_reg, gsh_next;

    // output register
    logic                              out_load;
    logic [tme_pkg::KIND_BITS-1:0]     o_kind_reg, o_kind_next;
    logic [COORD_BITS-1:0]             o_x_reg, o_x_next, o_y_reg, o_y_next, o_z_reg, o_z_next;
    logic                              o_zc_reg, o_zc_next, o_fc_reg, o_fc_next;
    logic                              o_last_reg, o_last_next;
    logic [FW-1:0]                     o_feed_reg, o_feed_next;
    logic [EXTRUDE_BITS-1:0]           o_ext_reg, o_ext_next;

    // datapath helpers
    logic [FW-1:0]                     travel_feed;
    logic                              same_move;
    logic [COORD_BITS:0]               dx, dy, dx_neg, dy_neg;
    logic [COORD_BITS-1:0]             ax, ay;
    logic [SUM_BITS-1:0]               add_x, add_y, sum_step;
    logic [REM_BITS-1:0]               rem_sh, trial, rem_step;
    logic                              root_fits;
    logic [ROOT_BITS-1:0]              root_step;
    logic [PROD_W-1:0]                 prod_step;
    logic [WIDE_W-1:0]                 inc_wide;
    logic                              out_free;

    assign travel_feed = tme_pkg::feed_of(travel_speed_reg);
    assign same_move   = (tx_reg == prev_x_reg) && (ty_reg == prev_y_reg)
                      && (tz_reg == prev_z_reg) && (feed_reg == prev_feed_reg);

    // sign-extended differences and magnitudes, fit COORD_BITS unsigned
    assign dx     = {tx_reg[COORD_BITS-1], tx_reg} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
    assign dy     = {ty_reg[COORD_BITS-1], ty_reg} - {prev_y_reg[COORD_BITS-1], prev_y_reg};
    assign dx_neg = -dx;
    assign dy_neg = -dy;
    assign ax     = dx[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    assign ay     = dy[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy[COORD_BITS-1:0];

    // squaring step: one multiplier bit of each axis per cycle
    assign add_x    = mpx_reg[0] ? SUM_BITS'(mcx_reg) : '0;
    assign add_y    = mpy_reg[0] ? SUM_BITS'(mcy_reg) : '0;
    assign sum_step = sum_reg + add_x + add_y;

    // restoring square root step: bring down one bit pair
    assign rem_sh    = {rem_reg[REM_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign root_fits = (rem_sh >= trial);
    assign rem_step  = root_fits ? (rem_sh - trial) : rem_sh;
    assign root_step = {root_reg[ROOT_BITS-2:0], root_fits};

    // gain multiply step: one gain bit per cycle, lsb first
    assign prod_step = prod_reg + (gsh_reg[0] ? mmc_reg : '0);
    assign inc_wide  = WIDE_W'(prod_step[PROD_W-1:tme_pkg::GAIN_BITS]);

    // output register frees when empty or taken this cycle
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next          = state_reg;
        travel_speed_next   = travel_speed_reg;
        retract_length_next = retract_length_reg;
        extrude_gain_next   = extrude_gain_reg;
        prev_x_next         = prev_x_reg;
        prev_y_next         = prev_y_reg;
        prev_z_next         = prev_z_reg;
        prev_feed_next      = prev_feed_reg;
        acc_next            = acc_reg;
        cnt_next            = cnt_reg;
        print_next          = print_reg;
        retr_next           = retr_reg;
        tx_next             = tx_reg;
        ty_next             = ty_reg;
        tz_next             = tz_reg;
        feed_next           = feed_reg;
        mcx_next            = mcx_reg;
        mcy_next            = mcy_reg;
        mpx_next            = mpx_reg;
        mpy_next            = mpy_reg;
        sum_next            = sum_reg;
        rad_next            = rad_reg;
        root_next           = root_reg;
        rem_next            = rem_reg;
        mmc_next            = mmc_reg;
        gsh_next            = gsh_reg;
        prod_next           = prod_reg;
        out_load            = 1'b0;
        o_kind_next         = o_kind_reg;
        o_x_next            = o_x_reg;
        o_y_next            = o_y_reg;
        o_z_next            = o_z_reg;
        o_zc_next           = o_zc_reg;
        o_feed_next         = o_feed_reg;
        o_fc_next           = o_fc_reg;
        o_ext_next          = o_ext_reg;
        o_last_next         = o_last_reg;

        // register writes
        if (cfg_we) begin
            case (cfg_addr)
                tme_pkg::CFG_TRAVEL_SPEED: begin
                    travel_speed_next = cfg_wdata[tme_pkg::SPEED_BITS-1:0];
                end
                tme_pkg::CFG_RETRACT_LENGTH: begin
                    retract_length_next = cfg_wdata[tme_pkg::RETRACT_BITS-1:0];
                end
                tme_pkg::CFG_EXTRUDE_GAIN: begin
                    extrude_gain_next = cfg_wdata[tme_pkg::GAIN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    tx_next    = s_x;
                    ty_next    = s_y;
                    tz_next    = s_z;
                    print_next = (s_tuser == tme_pkg::KIND_PRINT);
                    retr_next  = (s_tuser == tme_pkg::KIND_RETRACT);
                    feed_next  = (s_tuser == tme_pkg::KIND_PRINT)
                               ? tme_pkg::feed_of(s_speed) : travel_feed;
                    case (s_tuser)
                        tme_pkg::KIND_TRAVEL:  state_next = ST_CHECK;
                        tme_pkg::KIND_PRINT:   state_next = ST_CHECK;
                        tme_pkg::KIND_RETRACT: state_next = ST_RETR;
                        default:               state_next = ST_IDLE;  // unused kind dropped
                    endcase
                end
            end
            ST_CHECK: begin
                if (same_move) begin
                    state_next = retr_reg ? ST_UNRETR : ST_IDLE;
                end else if (print_reg) begin
                    mcx_next   = SQ_BITS'(ax);
                    mcy_next   = SQ_BITS'(ay);
                    mpx_next   = ax;
                    mpy_next   = ay;
                    sum_next   = '0;
                    cnt_next   = CNT_W'(COORD_BITS - 1);
                    state_next = ST_SQ;
                end else begin
                    state_next = ST_MOVE;
                end
            end
            ST_SQ: begin
                sum_next = sum_step;
                mcx_next = {mcx_reg[SQ_BITS-2:0], 1'b0};
                mcy_next = {mcy_reg[SQ_BITS-2:0], 1'b0};
                mpx_next = {1'b0, mpx_reg[COORD_BITS-1:1]};
                mpy_next = {1'b0, mpy_reg[COORD_BITS-1:1]};
                if (cnt_reg == '0) begin
                    rad_next   = RAD_BITS'(sum_step);
                    root_next  = '0;
                    rem_next   = '0;
                    cnt_next   = CNT_W'(ROOT_BITS - 1);
                    state_next = ST_ROOT;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_ROOT: begin
                rem_next  = rem_step;
                root_next = root_step;
                rad_next  = {rad_reg[RAD_BITS-3:0], 2'b00};
                if (cnt_reg == '0) begin
                    mmc_next   = PROD_W'(root_step);
                    gsh_next   = extrude_gain_reg;
                    prod_next  = '0;
                    cnt_next   = CNT_W'(tme_pkg::GAIN_BITS - 1);
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_MUL: begin
                prod_next = prod_step;
                mmc_next  = {mmc_reg[PROD_W-2:0], 1'b0};
                gsh_next  = {1'b0, gsh_reg[tme_pkg::GAIN_BITS-1:1]};
                if (cnt_reg == '0) begin
                    acc_next   = acc_reg + inc_wide[EXTRUDE_BITS-1:0];
                    state_next = ST_MOVE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_MOVE: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    o_kind_next    = print_reg ? tme_pkg::LINE_PRINT : tme_pkg::LINE_TRAVEL;
                    o_x_next       = tx_reg;
                    o_y_next       = ty_reg;
                    o_z_next       = tz_reg;
                    o_zc_next      = (tz_reg != prev_z_reg);
                    o_feed_next    = feed_reg;
                    o_fc_next      = (feed_reg != prev_feed_reg);
                    o_ext_next     = print_reg ? acc_reg : '0;
                    o_last_next    = !retr_reg;
                    prev_x_next    = tx_reg;
                    prev_y_next    = ty_reg;
                    prev_z_next    = tz_reg;
                    prev_feed_next = feed_reg;
                    state_next     = retr_reg ? ST_UNRETR : ST_IDLE;
                end
            end
            ST_RETR: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    o_kind_next = tme_pkg::LINE_EXTRUDE;
                    o_x_next    = '0;
                    o_y_next    = '0;
                    o_z_next    = '0;
                    o_zc_next   = 1'b0;
                    o_feed_next = feed_reg;
                    o_fc_next   = (feed_reg != prev_feed_reg);
                    o_ext_next  = acc_reg - EXTRUDE_BITS'(retract_length_reg);
                    o_last_next = 1'b0;
                    state_next  = ST_CHECK;
                end
            end
            ST_UNRETR: begin
                if (out_free) begin
                    out_load       = 1'b1;
                    o_kind_next    = tme_pkg::LINE_EXTRUDE;
                    o_x_next       = '0;
                    o_y_next       = '0;
                    o_z_next       = '0;
                    o_zc_next      = 1'b0;
                    o_feed_next    = feed_reg;
                    o_fc_next      = 1'b0;
                    o_ext_next     = acc_reg;
                    o_last_next    = 1'b1;
                    prev_feed_next = feed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // result valid: set on load, cleared when taken
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state, configuration and move history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            travel_speed_reg   <= tme_pkg::TRAVEL_SPEED_RST;
            retract_length_reg <= tme_pkg::RETRACT_LENGTH_RST;
            extrude_gain_reg   <= tme_pkg::EXTRUDE_GAIN_RST;
            prev_x_reg         <= '0;
            prev_y_reg         <= '0;
            prev_z_reg         <= '0;
            prev_feed_reg      <= '0;
            acc_reg            <= '0;
            m_valid_reg        <= 1'b0;
            cnt_reg            <= '0;
        end else begin
            state_reg          <= state_next;
            travel_speed_reg   <= travel_speed_next;
            retract_length_reg <= retract_length_next;
            extrude_gain_reg   <= extrude_gain_next;
            prev_x_reg         <= prev_x_next;
            prev_y_reg         <= prev_y_next;
            prev_z_reg         <= prev_z_next;
            prev_feed_reg      <= prev_feed_next;
            acc_reg            <= acc_next;
            m_valid_reg        <= m_valid_next;
            cnt_reg            <= cnt_next;
        end
    end

    // payload, arithmetic and output registers, no reset
    always_ff @(posedge aclk) begin
        print_reg   <= print_next;
        retr_reg    <= retr_next;
        tx_reg      <= tx_next;
        ty_reg      <= ty_next;
        tz_reg      <= tz_next;
        feed_reg    <= feed_next;
        mcx_reg     <= mcx_next;
        mcy_reg     <= mcy_next;
        mpx_reg     <= mpx_next;
        mpy_reg     <= mpy_next;
        sum_reg     <= sum_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        rem_reg     <= rem_next;
        mmc_reg     <= mmc_next;
        gsh_reg     <= gsh_next;
        prod_reg    <= prod_next;
        o_kind_reg  <= o_kind_next;
        o_x_reg     <= o_x_next;
        o_y_reg     <= o_y_next;
        o_z_reg     <= o_z_next;
        o_zc_reg    <= o_zc_next;
        o_feed_reg  <= o_feed_next;
        o_fc_reg    <= o_fc_next;
        o_ext_reg   <= o_ext_next;
        o_last_reg  <= o_last_next;
    end

    // result beat packing
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = M_DATA_W'({o_ext_reg, o_fc_reg, o_feed_reg, o_zc_reg,
                                 o_z_reg, o_y_reg, o_x_reg});

    // checks
    logic                 chk_travel_line, chk_extrude_line, chk_unretract;
    logic                 chk_zero_coords, chk_rem_ok;
    logic [REM_BITS-1:0]  chk_root_dbl;

    assign chk_travel_line  = m_valid_reg && (o_kind_reg == tme_pkg::LINE_TRAVEL);
    assign chk_extrude_line = m_valid_reg && (o_kind_reg == tme_pkg::LINE_EXTRUDE);
    assign chk_unretract    = chk_extrude_line && o_last_reg;
    assign chk_zero_coords  = (o_x_reg == '0) && (o_y_reg == '0) && (o_z_reg == '0)
                           && !o_zc_reg;
    assign chk_root_dbl     = REM_BITS'({root_reg, 1'b0});
    assign chk_rem_ok       = (rem_reg <= chk_root_dbl);

    `ASSERT_IMPLY(a_travel_no_ext, aclk, aresetn, chk_travel_line, o_ext_reg == '0,
        "travel line carries an extruder value")
    `ASSERT_IMPLY(a_extrude_no_coords, aclk, aresetn, chk_extrude_line, chk_zero_coords,
        "extruder-only line carries coordinates")
    `ASSERT_IMPLY(a_unretract_no_fc, aclk, aresetn, chk_unretract, !o_fc_reg,
        "unretract line flags a feed change")
    `ASSERT_IMPLY(a_root_rem_bound, aclk, aresetn, state_reg == ST_ROOT, chk_rem_ok,
        "square root remainder exceeds twice the partial root")

endmodule

@@ test/tme_line_checker.sv @@
// result checker of the toolpath move emitter: expected motion lines and beat compare
module tme_line_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [tme_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [tme_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [71:0]                        s_tdata,  // target_x, target_y, target_z,
                                                         // print_speed
    input  logic [tme_pkg::KIND_BITS-1:0]      s_tuser,  // kind
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [119:0]                       m_tdata,  // out_x, out_y, out_z, z_changed,
                                                         // feed, feed_changed, extruder_total
    input  logic [tme_pkg::KIND_BITS-1:0]      m_tuser,  // line_kind
    input  logic                               m_tlast,  // last
    output int                                 mismatch_count,
    output int                                 open_lines,
    output int                                 lines_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = tme_pkg::COORD_BITS_DEF;
    localparam int EW = tme_pkg::EXTRUDE_BITS_DEF;
    localparam int FB = tme_pkg::FEED_BITS;
    localparam int KB = tme_pkg::KIND_BITS;
    localparam int SB = tme_pkg::SPEED_BITS;
    localparam int FEED_PER_MMS = 60;
    localparam int OFS_ZC   = 3 * CW;
    localparam int OFS_FEED = 3 * CW + 1;
    localparam int OFS_FC   = 3 * CW + 1 + FB;
    localparam int OFS_EXT  = 3 * CW + 2 + FB;

    typedef struct packed {
        logic [KB-1:0]        line_kind;
        logic [CW-1:0]        x;
        logic [CW-1:0]        y;
        logic [CW-1:0]        z;
        logic                 z_changed;
        logic [FB-1:0]        feed;
        logic                 feed_changed;
        logic [EW-1:0]        extruder;
        logic                 last;
    } motion_line_t;

    motion_line_t expected_lines[$];

    logic [SB-1:0]                    travel_speed;
    logic [tme_pkg::RETRACT_BITS-1:0] retract_length;
    logic [tme_pkg::GAIN_BITS-1:0]    extrude_gain;
    logic [CW-1:0]                    last_x, last_y, last_z;
    logic [FB-1:0]                    last_feed;
    logic [EW-1:0]                    extruder_pos;

    function automatic logic [FB-1:0] to_feed(input logic [SB-1:0] speed);
        return FB'(speed) * FB'(FEED_PER_MMS);
    endfunction

    function automatic logic [63:0] axis_span(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic signed [CW:0] d;
        d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
        if (d < 0)
            d = -d;
        return {{(64-CW-1){1'b0}}, d};
    endfunction

    // truncated integer square root, two bits per step
    function automatic logic [63:0] path_length(input logic [63:0] sq);
        logic [63:0] root, rem, trial;
        int i;
        root = '0;
        rem  = '0;
        for (i = 31; i >= 0; i--) begin
            rem   = (rem << 2) | ((sq >> (2 * i)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    task automatic push_line(input logic [KB-1:0] lk, input logic [CW-1:0] x,
                             input logic [CW-1:0] y, input logic [CW-1:0] z, input logic zc,
                             input logic [FB-1:0] feed, input logic fc,
                             input logic [EW-1:0] ext, input logic last);
        motion_line_t ln;
        ln = '{lk, x, y, z, zc, feed, fc, ext, last};
        expected_lines.push_back(ln);
    endtask

    task automatic plan_move(input logic is_print, input logic [CW-1:0] x,
                             input logic [CW-1:0] y, input logic [CW-1:0] z,
                             input logic [FB-1:0] feed, input logic last);
        logic [63:0] ax, ay, len, prod;
        logic [EW-1:0] ext;
        // same spot at the same feed is dropped
        if (x == last_x && y == last_y && z == last_z && feed == last_feed)
            return;
        ext = '0;
        if (is_print) begin
            ax   = axis_span(x, last_x);
            ay   = axis_span(y, last_y);
            len  = path_length(ax * ax + ay * ay);
            prod = len * {48'd0, extrude_gain};
            extruder_pos = extruder_pos + prod[EW+15:16];
            ext = extruder_pos;
        end
        push_line(is_print ? tme_pkg::LINE_PRINT : tme_pkg::LINE_TRAVEL, x, y, z,
                  z != last_z, feed, feed != last_feed, ext, last);
        last_x    = x;
        last_y    = y;
        last_z    = z;
        last_feed = feed;
    endtask

    task automatic predict_move_lines(input logic [KB-1:0] kind,
                                      input logic [71:0] data);
        logic [FB-1:0] tfeed;
        logic [CW-1:0] x, y, z;
        x = data[CW-1:0];
        y = data[2*CW-1:CW];
        z = data[3*CW-1:2*CW];
        tfeed = to_feed(travel_speed);
        case (kind)
            tme_pkg::KIND_TRAVEL: plan_move(1'b0, x, y, z, tfeed, 1'b1);
            tme_pkg::KIND_PRINT:  plan_move(1'b1, x, y, z, to_feed(data[3*CW+SB-1:3*CW]), 1'b1);
            tme_pkg::KIND_RETRACT: begin
                push_line(tme_pkg::LINE_EXTRUDE, '0, '0, '0, 1'b0, tfeed, tfeed != last_feed,
                          extruder_pos - EW'(retract_length), 1'b0);
                plan_move(1'b0, x, y, z, tfeed, 1'b0);
                push_line(tme_pkg::LINE_EXTRUDE, '0, '0, '0, 1'b0, tfeed, 1'b0,
                          extruder_pos, 1'b1);
                last_feed = tfeed;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_line();
        motion_line_t exp;
        if (expected_lines.size() == 0) begin
            mismatch_count++;
            $display("%0t: result beat expected none got kind %0h data %0h last %0b",
                     $time, m_tuser, m_tdata, m_tlast);
            return;
        end
        exp = expected_lines.pop_front();
        lines_checked++;
        check_field("line_kind", 64'(exp.line_kind), 64'(m_tuser));
        check_field("out_x", 64'(exp.x), 64'(m_tdata[CW-1:0]));
        check_field("out_y", 64'(exp.y), 64'(m_tdata[2*CW-1:CW]));
        check_field("out_z", 64'(exp.z), 64'(m_tdata[3*CW-1:2*CW]));
        check_field("z_changed", 64'(exp.z_changed), 64'(m_tdata[OFS_ZC]));
        check_field("feed", 64'(exp.feed), 64'(m_tdata[OFS_FEED+FB-1:OFS_FEED]));
        check_field("feed_changed", 64'(exp.feed_changed), 64'(m_tdata[OFS_FC]));
        check_field("extruder_total", 64'(exp.extruder), 64'(m_tdata[OFS_EXT+EW-1:OFS_EXT]));
        check_field("last", 64'(exp.last), 64'(m_tlast));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            travel_speed   = tme_pkg::TRAVEL_SPEED_RST;
            retract_length = tme_pkg::RETRACT_LENGTH_RST;
            extrude_gain   = tme_pkg::EXTRUDE_GAIN_RST;
            last_x         = '0;
            last_y         = '0;
            last_z         = '0;
            last_feed      = '0;
            extruder_pos   = '0;
            mismatch_count = 0;
            lines_checked  = 0;
            expected_lines.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    tme_pkg::CFG_TRAVEL_SPEED:
                        travel_speed   = cfg_wdata[SB-1:0];
                    tme_pkg::CFG_RETRACT_LENGTH:
                        retract_length = cfg_wdata[tme_pkg::RETRACT_BITS-1:0];
                    tme_pkg::CFG_EXTRUDE_GAIN:
                        extrude_gain   = cfg_wdata[tme_pkg::GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_line();
            if (s_tvalid && s_tready)
                predict_move_lines(s_tuser, s_tdata);
        end
        open_lines <= expected_lines.size();
    end

endmodule

@@ test/tb_top.sv @@
// testbench top of the toolpath move emitter: clock, reset, stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW    = tme_pkg::COORD_BITS_DEF;
    localparam int SB    = tme_pkg::SPEED_BITS;
    localparam int KB    = tme_pkg::KIND_BITS;
    localparam int S_RAW = 3 * CW + SB;
    localparam int S_W   = ((S_RAW + 7) / 8) * 8;
    localparam int M_W   = ((3 * CW + 2 + tme_pkg::FEED_BITS + tme_pkg::EXTRUDE_BITS_DEF + 7)
                            / 8) * 8;

    localparam logic [KB-1:0] KIND_UNUSED = 2'd3;   // spare code, block ignores it
    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

    localparam int RESET_CYCLES    = 9;
    localparam int MAX_GAP         = 13;
    localparam int DRAIN_CYCLES    = 150;   // longer than a print move in flight
    localparam int SQUEEZE_AT      = 60;    // item count that starts the long sink stall
    localparam int SQUEEZE_CYCLES  = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PHASES   = 3;
    localparam int ITEMS_PER_PHASE = 44;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_we;
    logic [tme_pkg::CFG_ADDR_BITS-1:0] cfg_addr;
    logic [tme_pkg::CFG_DATA_BITS-1:0] cfg_wdata;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [S_W-1:0]                    s_tdata;  // target_x, target_y, target_z, print_speed
    logic [KB-1:0]                     s_tuser;  // kind
    logic                              m_tvalid;
    logic                              m_tready;
    logic [M_W-1:0]                    m_tdata;  // out_x, out_y, out_z, z_changed, feed,
                                                 // feed_changed, extruder_total
    logic [KB-1:0]                     m_tuser;  // line_kind
    logic                              m_tlast;  // last

    int mismatch_count;
    int open_lines;
    int lines_checked;

    // stimulus bookkeeping
    int items_sent = 0;
    int settings   = 1;      // reset values count as the first setting
    int quiet_cycles = 0;
    bit no_idle  = 1'b0;     // both sides run without gaps while set
    bit squeezed = 1'b0;
    logic [CW-1:0] cur_x = '0, cur_y = '0, cur_z = '0;
    logic [SB-1:0] cur_spd = '0;

    toolpath_move_emitter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // watches both channels and the register port, predicts and compares
    tme_line_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .open_lines     (open_lines),
        .lines_checked  (lines_checked)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result sink: random hold-off after every beat, one long stall mid-run
    initial begin : result_sink
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready)
                hold = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            // long stall while the sender keeps offering, so the block backs up
            if (!squeezed && items_sent >= SQUEEZE_AT) begin
                hold = SQUEEZE_CYCLES;
                squeezed = 1'b1;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog: too long without any beat on either side ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("tb_top NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input beat, held until the block takes it
    task automatic send_move(input logic [KB-1:0] kind, input logic [CW-1:0] x,
                             input logic [CW-1:0] y, input logic [CW-1:0] z,
                             input logic [SB-1:0] spd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_W-S_RAW){1'b0}}, spd, z, y, x};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        cur_x   = x;
        cur_y   = y;
        cur_z   = z;
        cur_spd = spd;
    endtask

    // all three registers on back-to-back cycles, block idle
    task automatic write_config(input logic [SB-1:0] ts,
                                input logic [tme_pkg::RETRACT_BITS-1:0] rl,
                                input logic [tme_pkg::GAIN_BITS-1:0] gain);
        cfg_we    <= 1'b1;
        cfg_addr  <= tme_pkg::CFG_TRAVEL_SPEED;
        cfg_wdata <= tme_pkg::CFG_DATA_BITS'(ts);
        @(posedge aclk);
        cfg_addr  <= tme_pkg::CFG_RETRACT_LENGTH;
        cfg_wdata <= tme_pkg::CFG_DATA_BITS'(rl);
        @(posedge aclk);
        cfg_addr  <= tme_pkg::CFG_EXTRUDE_GAIN;
        cfg_wdata <= tme_pkg::CFG_DATA_BITS'(gain);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings++;
    endtask

    // drop valid, wait for every expected line, then let a move in flight finish
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (open_lines != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // mostly short steps from the current spot, sometimes far or at the rails
    function automatic logic [CW-1:0] pick_coord(input logic [CW-1:0] cur);
        case ($urandom_range(0, 9))
            0:       return CW'($urandom);
            1:       return ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
            2:       return cur;
            default: return cur + CW'($urandom_range(0, 4000)) - CW'(2000);
        endcase
    endfunction

    task automatic send_random_move();
        logic [KB-1:0] kind;
        logic [CW-1:0] x, y, z;
        logic [SB-1:0] spd;
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            kind = tme_pkg::KIND_TRAVEL;
        else if (roll < 75)
            kind = tme_pkg::KIND_PRINT;
        else if (roll < 95)
            kind = tme_pkg::KIND_RETRACT;
        else
            kind = KIND_UNUSED;
        // repeats of the last target give dropped moves
        if ($urandom_range(0, 9) == 0) begin
            x   = cur_x;
            y   = cur_y;
            z   = cur_z;
            spd = cur_spd;
        end else begin
            x   = pick_coord(cur_x);
            y   = pick_coord(cur_y);
            z   = ($urandom_range(0, 3) == 0) ? pick_coord(cur_z) : cur_z;
            spd = ($urandom_range(0, 4) == 0) ? cur_spd : SB'($urandom);
        end
        send_move(kind, x, y, z, spd);
    endtask

    initial begin : stimulus
        int ph, n;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values: travel feed 4500
        send_move(tme_pkg::KIND_TRAVEL, '0, '0, '0, 8'd0);          // origin, only feed differs
        send_move(tme_pkg::KIND_TRAVEL, '0, '0, '0, 8'd0);          // same spot and feed, dropped
        send_move(tme_pkg::KIND_PRINT, C_MAX, C_MAX, '0, 8'd255);   // long diagonal, top speed
        send_move(tme_pkg::KIND_PRINT, C_MIN, C_MIN, C_MIN, 8'd0);  // full span, zero feed
        send_move(tme_pkg::KIND_PRINT, C_MIN, C_MIN, C_MIN, 8'd0);  // dropped print
        send_move(tme_pkg::KIND_PRINT, C_MIN, C_MIN, C_MIN, 8'd10); // zero length, new feed
        send_move(tme_pkg::KIND_RETRACT, C_MAX, C_MIN, C_MAX, 8'd0); // retract, travel, unretract
        send_move(tme_pkg::KIND_RETRACT, C_MAX, C_MIN, C_MAX, 8'd0); // travel inside is dropped
        send_move(KIND_UNUSED, CW'($urandom), CW'($urandom), CW'($urandom), 8'hFF);
        send_move(tme_pkg::KIND_PRINT, CW'(1000), C_MIN, C_MAX, 8'd75);  // feed equals travel feed
        send_move(tme_pkg::KIND_TRAVEL, CW'(1000), C_MIN, '0, 8'd0);     // only z moves
        send_move(tme_pkg::KIND_PRINT, CW'(1003), C_MIN + CW'(4), '0, 8'd75);
        wait_idle();

        // slowest travel, no retraction, full gain
        write_config(8'd1, 16'd0, 16'hFFFF);
        send_move(tme_pkg::KIND_RETRACT, '0, '0, '0, 8'd0);
        send_move(tme_pkg::KIND_PRINT, C_MAX, '0, '0, 8'd1);
        send_move(tme_pkg::KIND_TRAVEL, '0, '0, CW'(5), 8'd0);
        send_move(tme_pkg::KIND_RETRACT, '0, '0, CW'(5), 8'd0);
        wait_idle();

        // fastest travel, longest retraction, zero gain
        write_config(8'd255, 16'hFFFF, 16'd0);
        send_move(tme_pkg::KIND_RETRACT, C_MIN, C_MAX, '0, 8'd0);  // retraction at the longest length
        send_move(tme_pkg::KIND_PRINT, '0, '0, '0, 8'd255);
        send_move(KIND_UNUSED, C_MAX, C_MIN, C_MAX, 8'd0);
        send_move(tme_pkg::KIND_PRINT, C_MAX, C_MAX, C_MAX, 8'd128);
        wait_idle();

        // random phases, the middle one without idling
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: write_config(8'($urandom_range(1, 255)), 16'($urandom), 16'($urandom));
                1: write_config(8'd255, 16'($urandom), 16'hFFFF);
                default: write_config(8'd1, 16'd0, 16'($urandom));
            endcase
            no_idle = (ph == 1);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_move();
            wait_idle();
            no_idle = 1'b0;
        end

        $display("ran %0d move items of all kinds under %0d register settings",
                 items_sent, settings);
        $display("%0d result beats checked, %0d mismatches, sink stall %0s",
                 lines_checked, mismatch_count, squeezed ? "done" : "missed");
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
